// ----- rtl/ngs_pkg.sv -----
// Package for the n-body gravity Euler step core: payload structs, register
// indexes, arithmetic unit command types and sequencer states.
// No dependencies.
package ngs_pkg;

   localparam int unsigned FIELD_W   = 48;
   localparam int unsigned CSR_W     = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned WIDE_W    = 128;
   localparam int unsigned ITER_W    = 8;
   localparam int unsigned CNT_W     = 7;
   localparam int unsigned ABS_W     = 49;   // magnitude of a 49-bit difference
   localparam int unsigned R2_W      = 98;   // sum of two squared differences
   localparam int unsigned ROOT_W    = 50;
   localparam int unsigned GM_W      = 80;   // 32-bit constant times 48-bit mass
   localparam int unsigned SUM_W     = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAV_CONST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_THRESHOLD = 2'd2;

   localparam logic [CSR_W-1:0] GRAV_CONST_RESET = 32'd1230397829;
   localparam logic [CSR_W-1:0] TIME_STEP_RESET  = 32'd65536;
   localparam logic [CSR_W-1:0] DIST_THR_RESET   = 32'd983040;

   localparam logic [ITER_W-1:0] ITER_ABS  = 8'd49;
   localparam logic [ITER_W-1:0] ITER_CSR  = 8'd32;
   localparam logic [ITER_W-1:0] ITER_SQRT = 8'd50;
   localparam logic [ITER_W-1:0] ITER_DIV  = 8'd128;

   localparam logic [SUM_W-1:0] SUM_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0] SUM_MIN   = 64'h8000_0000_0000_0000;
   localparam logic [SUM_W-1:0] STEP_CAP  = 64'h4000_0000_0000_0000;
   localparam logic [FIELD_W-1:0] FIELD_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [FIELD_W-1:0] FIELD_MIN = 48'h8000_0000_0000;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SOURCE = 1'b1;

   typedef struct packed {
      logic                      op;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic        [FIELD_W-1:0] mass;
      logic                      last;
   } ngs_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] new_pos_x;
      logic signed [FIELD_W-1:0] new_pos_y;
      logic signed [FIELD_W-1:0] new_vel_x;
      logic signed [FIELD_W-1:0] new_vel_y;
   } ngs_rsp_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } ngs_alu_op_type;

   typedef struct packed {
      logic              start;
      ngs_alu_op_type    op;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
      logic [ITER_W-1:0] iter;
   } ngs_alu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] result;
   } ngs_alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_THR,
      ST_CHK,
      ST_SQRT,
      ST_GM,
      ST_NUM,
      ST_Q1,
      ST_A,
      ST_ACC,
      ST_FIN,
      ST_DV,
      ST_DP,
      ST_OUT
   } ngs_state_type;

endpackage

// ----- rtl/ngs_alu.sv -----
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (or bit pair) per cycle on one adder.
// Depends on ngs_pkg.
module ngs_alu import ngs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ngs_alu_cmd_type cmd,
   output ngs_alu_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   ngs_alu_op_type       op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WIDE_W:0]      acc_ff, acc_in;
   logic [WIDE_W-1:0]    opa_ff, opa_in;
   logic [WIDE_W-1:0]    opb_ff, opb_in;

   logic [WIDE_W+1:0]    add_x, add_y, add_sum;
   logic                 add_sub;
   logic [WIDE_W:0]      rem_shift;
   logic                 fits;

   // one adder serves all three operations
   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{(WIDE_W+1){1'b0}}, add_sub};
   assign fits    = ~add_sum[WIDE_W+1];

   always_comb begin
      add_x     = '0;
      add_y     = '0;
      add_sub   = 1'b0;
      rem_shift = '0;
      unique case (op_ff)
         ALU_MUL: begin
            add_x = {1'b0, acc_ff};
            add_y = {2'b00, opa_ff};
         end
         ALU_DIV: begin
            rem_shift = {acc_ff[WIDE_W-1:0], opa_ff[WIDE_W-1]};
            add_x     = {1'b0, rem_shift};
            add_y     = {2'b00, opb_ff};
            add_sub   = 1'b1;
         end
         ALU_SQRT: begin
            rem_shift = {acc_ff[WIDE_W-2:0], opa_ff[WIDE_W-1:WIDE_W-2]};
            add_x     = {1'b0, rem_shift};
            add_y     = {1'b0, opb_ff[WIDE_W-2:0], 2'b01};
            add_sub   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CNT_W'(cmd.iter - 8'd1);
         acc_in  = '0;
         opa_in  = cmd.a;
         opb_in  = cmd.b;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         unique case (op_ff)
            ALU_MUL: begin
               if (opb_ff[0]) begin
                  acc_in = add_sum[WIDE_W:0];
               end
               opa_in = {opa_ff[WIDE_W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[WIDE_W-1:1]};
            end
            ALU_DIV: begin
               acc_in = fits ? add_sum[WIDE_W:0] : rem_shift;
               opa_in = {opa_ff[WIDE_W-2:0], fits};
            end
            ALU_SQRT: begin
               acc_in = fits ? add_sum[WIDE_W:0] : rem_shift;
               opa_in = {opa_ff[WIDE_W-3:0], 2'b00};
               opb_in = {opb_ff[WIDE_W-2:0], fits};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   always_comb begin
      rsp.done = done_ff;
      unique case (op_ff)
         ALU_MUL:  rsp.result = acc_ff[WIDE_W-1:0];
         ALU_DIV:  rsp.result = opa_ff;
         ALU_SQRT: rsp.result = opb_ff;
         default:  rsp.result = acc_ff[WIDE_W-1:0];
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("alu started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("alu done held");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cmd.start && cnt_ff == '0) |=> done_ff)
      else $error("alu missed its last step");

endmodule

// ----- rtl/nbody_gravity_euler_step_core.sv -----
// Top level of the n-body gravity Euler step core: sequencer, body state,
// configuration registers and result register. Depends on ngs_pkg, ngs_alu.
//
// Use: send a load item (op 0) with the target body's position and velocity,
// then source items (op 1) with mass and position of each other body; the item
// marked last triggers the velocity and position update and one result item.
// Channels req_ and rsp_ move an item when valid is high and stall is low.
// Every multiply, divide and square root runs on the one shared bit-serial
// unit, one operation after another:
//   load item: taken in the idle state, or followed by the update when last;
//   source below the distance threshold: squares and threshold only;
//   contributing source: square root, mass product and up to two divides per
//   axis (the divides dominate), plus the update when marked last.
// req_stall is high whenever an item is in progress.
// The result sits in an output register; the core takes the next item while a
// stalled result waits, and holds in its output step only if a second result
// is ready before the first is taken.
// Reset (synchronous) clears body state and sums and restores register values.
// csr_ writes are taken at any edge with csr_we high; write only when idle.
module nbody_gravity_euler_step_core import ngs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ngs_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ngs_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int SH_ALL = 4 * FRAC_BITS - 64;
   localparam int SH_L   = (SH_ALL > 0) ? SH_ALL : 0;
   localparam int SH_R   = (SH_ALL < 0) ? -SH_ALL : 0;
   localparam int SH_V   = 2 * FRAC_BITS;
   localparam int SH_P   = FRAC_BITS;

   ngs_state_type        state_ff, state_in;
   logic                 launched_ff, launched_in;
   logic                 axis_ff, axis_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ngs_rsp_type          rsp_data_ff, rsp_data_in;
   logic [CSR_W-1:0]     grav_ff, grav_in, ts_ff, ts_in, thr_ff, thr_in;
   logic [FIELD_W-1:0]   tpx_ff, tpx_in, tpy_ff, tpy_in, tvx_ff, tvx_in, tvy_ff, tvy_in;
   logic [SUM_W-1:0]     sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic [ABS_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [FIELD_W-1:0]   mass_ff, mass_in;
   logic [R2_W-1:0]      r2_ff, r2_in;
   logic [SUM_W-1:0]     thr2_ff, thr2_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [GM_W-1:0]      gm_ff, gm_in;
   logic [WIDE_W-1:0]    tmp_ff, tmp_in, den_ff, den_in;

   ngs_alu_cmd_type      alu_cmd;
   ngs_alu_rsp_type      alu_rsp;

   logic                 req_fire, step_done, out_free, skip;
   logic [ABS_W-1:0]     dx_abs, dy_abs, d_sel, d_abs;
   logic [SUM_W-1:0]     sum_sel, sum_abs, term_mag, term;
   logic [SUM_W:0]       acc_sum;
   logic [SUM_W-1:0]     acc_sat;
   logic [FIELD_W-1:0]   vel_sel, vel_abs, pos_sel, base_sel, new_val;
   logic [WIDE_W-1:0]    r2_wide, num_l, den_r, shifted;
   logic                 prep_zero, step_neg;
   logic [SUM_W-1:0]     step_mag, step_val, upd_sum;

   ngs_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign step_done = launched_ff && alu_rsp.done;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dx_abs  = dx_ff[ABS_W-1] ? (~dx_ff + 1'b1) : dx_ff;
   assign dy_abs  = dy_ff[ABS_W-1] ? (~dy_ff + 1'b1) : dy_ff;
   assign d_sel   = axis_ff ? dy_ff : dx_ff;
   assign d_abs   = axis_ff ? dy_abs : dx_abs;
   assign sum_sel = axis_ff ? sumy_ff : sumx_ff;
   assign sum_abs = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
   assign vel_sel = axis_ff ? tvy_ff : tvx_ff;
   assign vel_abs = vel_sel[FIELD_W-1] ? (~vel_sel + 1'b1) : vel_sel;
   assign pos_sel = axis_ff ? tpy_ff : tpx_ff;

   assign skip = (r2_ff == '0) || (r2_ff < {{(R2_W-SUM_W){1'b0}}, thr2_ff});

   // scale q1 and r2 so that the second divide carries the 2^(4F-64) factor
   assign r2_wide   = {{(WIDE_W-R2_W){1'b0}}, r2_ff};
   assign num_l     = alu_rsp.result << SH_L;
   assign den_r     = r2_wide << SH_R;
   assign prep_zero = (SH_R != 0) && ((r2_wide >> (WIDE_W - SH_R)) != '0);

   // saturate the axis term and add it to the sum with saturation
   assign term_mag = (tmp_ff[WIDE_W-1:SUM_W-1] != '0) ? SUM_MAX : tmp_ff[SUM_W-1:0];
   assign term     = d_sel[ABS_W-1] ? (~term_mag + 1'b1) : term_mag;
   assign acc_sum  = {sum_sel[SUM_W-1], sum_sel} + {term[SUM_W-1], term};
   assign acc_sat  = (acc_sum[SUM_W] != acc_sum[SUM_W-1]) ?
                     (acc_sum[SUM_W] ? SUM_MIN : SUM_MAX) : acc_sum[SUM_W-1:0];

   // scaled step for the Euler update, capped and signed
   assign shifted  = (state_ff == ST_DV) ? (alu_rsp.result >> SH_V)
                                         : (alu_rsp.result >> SH_P);
   assign step_mag = (shifted > {{(WIDE_W-SUM_W){1'b0}}, STEP_CAP}) ?
                     STEP_CAP : shifted[SUM_W-1:0];
   assign step_neg = (state_ff == ST_DV) ? sum_sel[SUM_W-1] : vel_sel[FIELD_W-1];
   assign step_val = step_neg ? (~step_mag + 1'b1) : step_mag;
   assign base_sel = (state_ff == ST_DV) ? vel_sel : pos_sel;
   assign upd_sum  = {{(SUM_W-FIELD_W){base_sel[FIELD_W-1]}}, base_sel} + step_val;

   always_comb begin
      if (!upd_sum[SUM_W-1] && (upd_sum[SUM_W-2:FIELD_W-1] != '0)) begin
         new_val = FIELD_MAX;
      end else if (upd_sum[SUM_W-1] && (upd_sum[SUM_W-2:FIELD_W-1] != '1)) begin
         new_val = FIELD_MIN;
      end else begin
         new_val = upd_sum[FIELD_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_SOURCE) begin
                  state_in = ST_SQX;
               end else if (req_data.last) begin
                  state_in = ST_DV;
               end
            end
         end
         ST_SQX:  if (step_done) state_in = ST_SQY;
         ST_SQY:  if (step_done) state_in = ST_THR;
         ST_THR:  if (step_done) state_in = ST_CHK;
         ST_CHK:  state_in = skip ? ST_FIN : ST_SQRT;
         ST_SQRT: if (step_done) state_in = ST_GM;
         ST_GM:   if (step_done) state_in = ST_NUM;
         ST_NUM:  if (step_done) state_in = ST_Q1;
         ST_Q1:   if (step_done) state_in = prep_zero ? ST_ACC : ST_A;
         ST_A:    if (step_done) state_in = ST_ACC;
         ST_ACC:  state_in = axis_ff ? ST_FIN : ST_NUM;
         ST_FIN:  state_in = last_ff ? ST_DV : ST_IDLE;
         ST_DV:   if (step_done && axis_ff) state_in = ST_DP;
         ST_DP:   if (step_done && axis_ff) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and unit commands
   always_comb begin
      launched_in  = launched_ff;
      axis_in      = axis_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      tpx_in = tpx_ff;  tpy_in = tpy_ff;  tvx_in = tvx_ff;  tvy_in = tvy_ff;
      sumx_in = sumx_ff;  sumy_in = sumy_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  mass_in = mass_ff;
      r2_in = r2_ff;  thr2_in = thr2_ff;  root_in = root_ff;  gm_in = gm_ff;
      tmp_in = tmp_ff;  den_in = den_ff;
      alu_cmd       = '0;
      alu_cmd.op    = ALU_MUL;
      alu_cmd.iter  = ITER_ABS;

      unique case (state_ff)
         ST_SQX: begin
            alu_cmd.a = {{(WIDE_W-ABS_W){1'b0}}, dx_abs};
            alu_cmd.b = {{(WIDE_W-ABS_W){1'b0}}, dx_abs};
         end
         ST_SQY: begin
            alu_cmd.a = {{(WIDE_W-ABS_W){1'b0}}, dy_abs};
            alu_cmd.b = {{(WIDE_W-ABS_W){1'b0}}, dy_abs};
         end
         ST_THR: begin
            alu_cmd.a    = {{(WIDE_W-CSR_W){1'b0}}, thr_ff};
            alu_cmd.b    = {{(WIDE_W-CSR_W){1'b0}}, thr_ff};
            alu_cmd.iter = ITER_CSR;
         end
         ST_SQRT: begin
            alu_cmd.op   = ALU_SQRT;
            alu_cmd.a    = {2'b00, r2_ff, 28'd0};
            alu_cmd.iter = ITER_SQRT;
         end
         ST_GM: begin
            alu_cmd.a    = {{(WIDE_W-FIELD_W){1'b0}}, mass_ff};
            alu_cmd.b    = {{(WIDE_W-CSR_W){1'b0}}, grav_ff};
            alu_cmd.iter = ITER_CSR;
         end
         ST_NUM: begin
            alu_cmd.a = {{(WIDE_W-GM_W){1'b0}}, gm_ff};
            alu_cmd.b = {{(WIDE_W-ABS_W){1'b0}}, d_abs};
         end
         ST_Q1: begin
            alu_cmd.op   = ALU_DIV;
            alu_cmd.a    = tmp_ff;
            alu_cmd.b    = {{(WIDE_W-ROOT_W){1'b0}}, root_ff};
            alu_cmd.iter = ITER_DIV;
         end
         ST_A: begin
            alu_cmd.op   = ALU_DIV;
            alu_cmd.a    = tmp_ff;
            alu_cmd.b    = den_ff;
            alu_cmd.iter = ITER_DIV;
         end
         ST_DV: begin
            alu_cmd.a    = {{(WIDE_W-SUM_W){1'b0}}, sum_abs};
            alu_cmd.b    = {{(WIDE_W-CSR_W){1'b0}}, ts_ff};
            alu_cmd.iter = ITER_CSR;
         end
         ST_DP: begin
            alu_cmd.a    = {{(WIDE_W-FIELD_W){1'b0}}, vel_abs};
            alu_cmd.b    = {{(WIDE_W-CSR_W){1'b0}}, ts_ff};
            alu_cmd.iter = ITER_CSR;
         end
         default: begin
         end
      endcase

      // launch the shared unit once per compute step (once per axis in ST_DV and ST_DP), then wait for done
      unique case (state_ff)
         ST_SQX, ST_SQY, ST_THR, ST_SQRT, ST_GM, ST_NUM, ST_Q1, ST_A, ST_DV, ST_DP: begin
            if (!launched_ff) begin
               alu_cmd.start = 1'b1;
               launched_in   = 1'b1;
            end else if (alu_rsp.done) begin
               launched_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               axis_in = 1'b0;
               last_in = req_data.last;
               if (req_data.op == OP_LOAD) begin
                  tpx_in  = req_data.pos_x;
                  tpy_in  = req_data.pos_y;
                  tvx_in  = req_data.vel_x;
                  tvy_in  = req_data.vel_y;
                  sumx_in = '0;
                  sumy_in = '0;
               end else begin
                  dx_in   = {req_data.pos_x[FIELD_W-1], req_data.pos_x}
                          - {tpx_ff[FIELD_W-1], tpx_ff};
                  dy_in   = {req_data.pos_y[FIELD_W-1], req_data.pos_y}
                          - {tpy_ff[FIELD_W-1], tpy_ff};
                  mass_in = req_data.mass;
               end
            end
         end
         ST_SQX:  if (step_done) r2_in = alu_rsp.result[R2_W-1:0];
         ST_SQY:  if (step_done) r2_in = r2_ff + alu_rsp.result[R2_W-1:0];
         ST_THR:  if (step_done) thr2_in = alu_rsp.result[SUM_W-1:0];
         ST_SQRT: if (step_done) root_in = alu_rsp.result[ROOT_W-1:0];
         ST_GM:   if (step_done) gm_in = alu_rsp.result[GM_W-1:0];
         ST_NUM:  if (step_done) tmp_in = alu_rsp.result;
         ST_Q1: begin
            if (step_done) begin
               tmp_in = prep_zero ? '0 : num_l;
               den_in = den_r;
            end
         end
         ST_A:    if (step_done) tmp_in = alu_rsp.result;
         ST_ACC: begin
            if (axis_ff) begin
               sumy_in = acc_sat;
            end else begin
               sumx_in = acc_sat;
            end
            axis_in = !axis_ff;
         end
         ST_DV: begin
            if (step_done) begin
               if (axis_ff) begin
                  tvy_in = new_val;
               end else begin
                  tvx_in = new_val;
               end
               axis_in = !axis_ff;
            end
         end
         ST_DP: begin
            if (step_done) begin
               if (axis_ff) begin
                  tpy_in = new_val;
               end else begin
                  tpx_in = new_val;
               end
               axis_in = !axis_ff;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.new_pos_x = tpx_ff;
               rsp_data_in.new_pos_y = tpy_ff;
               rsp_data_in.new_vel_x = tvx_ff;
               rsp_data_in.new_vel_y = tvy_ff;
               sumx_in               = '0;
               sumy_in               = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      grav_in = grav_ff;
      ts_in   = ts_ff;
      thr_in  = thr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRAV_CONST:     grav_in = csr_wdata;
            CSR_TIME_STEP:      ts_in   = csr_wdata;
            CSR_DIST_THRESHOLD: thr_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= GRAV_CONST_RESET;
         ts_ff        <= TIME_STEP_RESET;
         thr_ff       <= DIST_THR_RESET;
         tpx_ff       <= '0;
         tpy_ff       <= '0;
         tvx_ff       <= '0;
         tvy_ff       <= '0;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         grav_ff      <= grav_in;
         ts_ff        <= ts_in;
         thr_ff       <= thr_in;
         tpx_ff       <= tpx_in;
         tpy_ff       <= tpy_in;
         tvx_ff       <= tvx_in;
         tvy_ff       <= tvy_in;
         sumx_ff      <= sumx_in;
         sumy_ff      <= sumy_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      mass_ff     <= mass_in;
      r2_ff       <= r2_in;
      thr2_ff     <= thr2_in;
      root_ff     <= root_in;
      gm_ff       <= gm_in;
      tmp_ff      <= tmp_in;
      den_ff      <= den_in;
   end

   a_done_launched: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> launched_ff) else $error("unit done without a launch");
   a_start_once: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> !launched_ff) else $error("unit launched twice");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded");

endmodule
